// ----- sv/fau_pkg.sv -----
// package for the accelerometer fifo frame unpacker
// holds result types, reset values and constants; no dependencies
package fau_pkg;

  // default number of header bytes dropped at the start of each buffer
  localparam int unsigned HeaderBytesDef = 2;

  // frame limit register
  localparam int unsigned MaxFramesW   = 10;
  localparam logic [MaxFramesW-1:0] MaxFramesRst = 10'd1023;

  // field widths
  localparam int unsigned ByteW      = 8;
  localparam int unsigned AxisW      = 16;
  localparam int unsigned CountW     = 10;
  localparam int unsigned HeaderW    = 2;
  localparam int unsigned ByteIdxW   = 3;
  localparam int unsigned FrameLen   = 6;
  localparam int unsigned PartialW   = ByteW * (FrameLen - 1);

  // axis word that marks a fifo underrun when it fills all three axes
  localparam logic [AxisW-1:0] UnderrunWord = 16'h8000;

  // depth of the result queue
  localparam int unsigned ResQueueDepth = 4;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_DONE  = 1'b1
  } result_kind_e;

  typedef struct packed {
    result_kind_e       kind;
    logic [AxisW-1:0]   accel_x;
    logic [AxisW-1:0]   accel_y;
    logic [AxisW-1:0]   accel_z;
    logic [CountW-1:0]  frame_index;
    logic [CountW-1:0]  frame_total;
    logic               run_end;
  } result_t;

endpackage

// ----- sv/fifo_accel_frame_unpacker_top.sv -----
// accelerometer fifo frame unpacker, top level
// strips header bytes, packs six-byte frames into three axis counts, reports block done
// depends on fau_pkg
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid_i, in_ready_o, data_byte_i,      | into block
//           | end_of_buffer_i                           |
//  out      | out_valid_o, out_ready_i, result_kind_o,  | out of block
//           | accel_x/y/z_o, frame_index_o,             |
//           | frame_total_o, run_end_o                  |
//  cfg      | cfg_we_i, cfg_wdata_i (frame limit)       | into block
//
// one byte is taken per cycle while in_ready_o is high; its state update is done in the
// accepting cycle and its zero, one or two results are written into a four-entry result queue.
// outputs show the queue head, so a result written into an empty queue is shown in the next cycle.
// in_ready_o is high while the queue has room for two results, so with out_ready_i high
// the block sustains one byte per cycle; a stalled output fills the queue and then stalls input.
// asynchronous active-low reset clears the block state, the queue and sets the frame limit to 1023.
module fifo_accel_frame_unpacker_top #(
  parameter int unsigned HEADER_BYTES = fau_pkg::HeaderBytesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [fau_pkg::MaxFramesW-1:0]      cfg_wdata_i,
  // input bytes
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [fau_pkg::ByteW-1:0]           data_byte_i,
  input  logic                                end_of_buffer_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                result_kind_o,
  output logic signed [fau_pkg::AxisW-1:0]    accel_x_o,
  output logic signed [fau_pkg::AxisW-1:0]    accel_y_o,
  output logic signed [fau_pkg::AxisW-1:0]    accel_z_o,
  output logic [fau_pkg::CountW-1:0]          frame_index_o,
  output logic [fau_pkg::CountW-1:0]          frame_total_o,
  output logic                                run_end_o
);
  import fau_pkg::*;

  localparam int unsigned PtrW = $clog2(ResQueueDepth);
  localparam int unsigned CntW = $clog2(ResQueueDepth + 1);
  localparam logic [HeaderW-1:0] HeaderRst = HeaderW'(HEADER_BYTES);
  localparam logic [ByteIdxW-1:0] LastByteIdx = ByteIdxW'(FrameLen - 1);

  // block state
  logic [MaxFramesW-1:0] frame_limit_q;
  logic [HeaderW-1:0]    header_left_q, header_left_d;
  logic [ByteIdxW-1:0]   byte_in_frame_q, byte_in_frame_d;
  logic [PartialW-1:0]   partial_q, partial_d;
  logic [CountW-1:0]     frames_done_q, frames_done_d;
  logic                  halted_q, halted_d;

  // result queue
  result_t               queue_q [ResQueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       count_q;

  logic                  in_fire, out_fire;
  logic                  frame_emit, done_emit;
  logic [AxisW-1:0]      ax, ay, az;
  logic [CountW-1:0]     total_after;
  result_t               frame_res, done_res, res_first, res_second;
  logic [1:0]            push_n;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // frame assembly and block state update
  always_comb begin
    header_left_d   = header_left_q;
    byte_in_frame_d = byte_in_frame_q;
    partial_d       = partial_q;
    frames_done_d   = frames_done_q;
    halted_d        = halted_q;
    frame_emit      = 1'b0;
    ax              = partial_q[AxisW-1:0];
    ay              = partial_q[2*AxisW-1:AxisW];
    az              = {data_byte_i, partial_q[PartialW-1:2*AxisW]};
    if (!halted_q) begin
      if (header_left_q != '0) begin
        header_left_d = header_left_q - 1'b1;
      end else if (frames_done_q < frame_limit_q) begin
        if (byte_in_frame_q != LastByteIdx) begin
          partial_d = partial_q | (PartialW'(data_byte_i) << (ByteW * byte_in_frame_q));
          byte_in_frame_d = byte_in_frame_q + 1'b1;
        end else begin
          byte_in_frame_d = '0;
          partial_d       = '0;
          if (ax == UnderrunWord && ay == UnderrunWord && az == UnderrunWord) begin
            halted_d = 1'b1;
          end else begin
            frame_emit    = 1'b1;
            frames_done_d = frames_done_q + 1'b1;
          end
        end
      end
    end
    total_after = frames_done_d;
    done_emit   = end_of_buffer_i;
    // end of buffer returns the frame assembly state to its reset values; the frame limit is kept
    if (end_of_buffer_i) begin
      header_left_d   = HeaderRst;
      byte_in_frame_d = '0;
      partial_d       = '0;
      frames_done_d   = '0;
      halted_d        = 1'b0;
    end
  end

  // result words for this byte
  always_comb begin
    frame_res.kind        = KIND_FRAME;
    frame_res.accel_x     = ax;
    frame_res.accel_y     = ay;
    frame_res.accel_z     = az;
    frame_res.frame_index = frames_done_q;
    frame_res.frame_total = '0;
    frame_res.run_end     = !done_emit;

    done_res.kind         = KIND_DONE;
    done_res.accel_x      = '0;
    done_res.accel_y      = '0;
    done_res.accel_z      = '0;
    done_res.frame_index  = '0;
    done_res.frame_total  = total_after;
    done_res.run_end      = 1'b1;

    res_first  = frame_emit ? frame_res : done_res;
    res_second = done_res;
    push_n     = 2'(frame_emit) + 2'(done_emit);
  end

  // block state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q   <= MaxFramesRst;
      header_left_q   <= HeaderRst;
      byte_in_frame_q <= '0;
      partial_q       <= '0;
      frames_done_q   <= '0;
      halted_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_limit_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        header_left_q   <= header_left_d;
        byte_in_frame_q <= byte_in_frame_d;
        partial_q       <= partial_d;
        frames_done_q   <= frames_done_d;
        halted_q        <= halted_d;
      end
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (in_fire && push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= res_first;
    end
    if (in_fire && push_n == 2'd2) begin
      queue_q[wr_ptr_q + 1'b1] <= res_second;
    end
  end

  // result queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (in_fire ? CntW'(push_n) : '0) - CntW'(out_fire);
    end
  end

  // handshakes and result outputs
  assign in_ready_o    = (count_q <= CntW'(ResQueueDepth - 2));
  assign out_valid_o   = (count_q != '0);
  assign result_kind_o = queue_q[rd_ptr_q].kind;
  assign accel_x_o     = queue_q[rd_ptr_q].accel_x;
  assign accel_y_o     = queue_q[rd_ptr_q].accel_y;
  assign accel_z_o     = queue_q[rd_ptr_q].accel_z;
  assign frame_index_o = queue_q[rd_ptr_q].frame_index;
  assign frame_total_o = queue_q[rd_ptr_q].frame_total;
  assign run_end_o     = queue_q[rd_ptr_q].run_end;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ResQueueDepth))
    else $error("result queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_of_buffer_i |=>
      frames_done_q == '0 && header_left_q == HeaderRst && !halted_q)
    else $error("block state not cleared after end of buffer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> byte_in_frame_q == '0 && header_left_q == '0)
    else $error("halted block holds a partial frame or header");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && push_n != 2'd0 && count_q == '0 |=> out_valid_o)
    else $error("result not presented after transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !end_of_buffer_i && frame_emit |=>
      frames_done_q == $past(frames_done_q) + 1'b1)
    else $error("frame count not advanced on emitted frame");

endmodule
